FILE: design/hp_pkg.sv
// Shared types and constants for the two-dimensional Halton point generator.
// No dependencies; every other file of the block depends on this package.
package hp_pkg;

    localparam int INDEX_WIDTH_DEF = 32;
    localparam int FRAC_WIDTH_DEF  = 32;
    localparam int FIELD_W         = 32;
    localparam int BASE_W          = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int DIV_BITS        = 8;

    localparam logic [BASE_W-1:0]  BASE_FIRST_RST  = 8'd2;
    localparam logic [BASE_W-1:0]  BASE_SECOND_RST = 8'd3;
    localparam logic [BASE_W-1:0]  BASE_MIN        = 8'd2;
    localparam logic [FIELD_W-1:0] START_INDEX_RST = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_FIRST  = 2'd0,
        CFG_BASE_SECOND = 2'd1,
        CFG_START_INDEX = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XCHK,
        ST_XDIV,
        ST_XSTORE,
        ST_FCHK,
        ST_FREAD,
        ST_FDIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
    } div_ctrl_t;

endpackage

FILE: design/hp_channels.sv
// Valid/ready channel interfaces for the Halton point generator.
// Depends on hp_pkg for the field widths.
interface hp_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface hp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [hp_pkg::FIELD_W-1:0] coord_first;
    logic [hp_pkg::FIELD_W-1:0] coord_second;
    logic [hp_pkg::FIELD_W-1:0] index_used;

    modport source (output valid, output coord_first, output coord_second,
                    output index_used, input ready);
    modport sink   (input valid, input coord_first, input coord_second,
                    input index_used, output ready);
endinterface

FILE: design/hp_divider.sv
// Shared restoring divider by an 8-bit base, eight quotient bits per cycle.
// Depends on hp_pkg. The dividend register is shifted in place into the quotient.
module hp_divider #(
    parameter int DW = 40
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hp_pkg::div_ctrl_t         ctrl,
    input  logic [DW-1:0]             load_value,
    input  logic [hp_pkg::BASE_W-1:0] base,
    output logic [DW-1:0]             quot,
    output logic [hp_pkg::BASE_W-1:0] rem,
    output logic                      busy
);
    import hp_pkg::*;

    localparam int STEPS = DW / DIV_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DW-1:0]     quot_reg;
    logic [BASE_W-1:0] rem_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DW-1:0]     quot_next;
    logic [BASE_W-1:0] rem_next;

    // Eight dependent compare-subtract steps on a 9-bit partial remainder.
    always_comb
    begin
        logic [BASE_W:0]   t;
        logic [DW-1:0]     q;
        logic [BASE_W-1:0] r;
        q = quot_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t = {r, q[DW-1]};
            q = {q[DW-2:0], 1'b0};
            if (t >= {1'b0, base})
            begin
                t    = t - {1'b0, base};
                q[0] = 1'b1;
            end
            r = t[BASE_W-1:0];
        end
        quot_next = q;
        rem_next  = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.start)
        begin
            cnt_reg <= CW'(STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            quot_reg <= load_value;
        end
        else if (cnt_reg != '0)
        begin
            quot_reg <= quot_next;
        end
        if (ctrl.start)
        begin
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign busy = (cnt_reg != '0);

endmodule

FILE: design/hp_digit_mem.sv
// Digit store: one write port, one registered read port.
// Depends on hp_pkg for the digit width.
module hp_digit_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [hp_pkg::BASE_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [hp_pkg::BASE_W-1:0] rdata
);
    import hp_pkg::*;

    logic [BASE_W-1:0] mem [DEPTH];
    logic [BASE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/halton_point_2d.sv
// Halton point generator, one point per request, one request at a time.
// Each coordinate takes, per base digit of the index, one divide on the shared divider to
// extract the digit and one to fold it. A new request is taken only when the previous
// point is finished. Reset is asynchronous: bases return to 2 and 3, start and sample
// index to 0, and the result register empties.
module halton_point_2d #(
    parameter int INDEX_WIDTH = hp_pkg::INDEX_WIDTH_DEF,
    parameter int FRAC_WIDTH  = hp_pkg::FRAC_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [hp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hp_pkg::FIELD_W-1:0]   cfg_data,
    hp_req_if.sink                       req,
    hp_rsp_if.source                     rsp
);
    import hp_pkg::*;

    localparam int WIDEST = (INDEX_WIDTH > FRAC_WIDTH + BASE_W) ? INDEX_WIDTH
                                                                : FRAC_WIDTH + BASE_W;
    localparam int DW     = ((WIDEST + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int AW     = $clog2(INDEX_WIDTH);
    localparam int CW     = $clog2(INDEX_WIDTH + 1);

    // Configuration
    logic [BASE_W-1:0]  base_first_reg;
    logic [BASE_W-1:0]  base_second_reg;
    logic [FIELD_W-1:0] start_index_reg;

    // Control and working state
    state_t                 state_reg, state_next;
    logic [INDEX_WIDTH-1:0] sample_index_reg;
    logic [INDEX_WIDTH-1:0] idx_used_reg;
    logic [CW-1:0]          count_reg;
    logic                   sel_reg;
    logic [FRAC_WIDTH-1:0]  coord_first_reg;

    // Result register
    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_first_reg;
    logic [FIELD_W-1:0] out_second_reg;
    logic [FIELD_W-1:0] out_index_reg;

    // Datapath wiring
    div_ctrl_t              div_ctrl;
    logic [DW-1:0]          div_value;
    logic [DW-1:0]          quot;
    logic [BASE_W-1:0]      rem;
    logic                   div_busy;
    logic [BASE_W-1:0]      base_raw;
    logic [BASE_W-1:0]      base_eff;
    logic [INDEX_WIDTH-1:0] idx_pick;
    logic [BASE_W-1:0]      digit;
    logic [AW-1:0]          raddr;
    logic                   accept;
    logic                   mem_we;
    logic                   cnt_dec;
    logic                   switch_coord;
    logic                   out_load;
    logic                   quot_zero;

    assign base_raw  = sel_reg ? base_second_reg : base_first_reg;
    assign base_eff  = (base_raw < BASE_MIN) ? BASE_MIN : base_raw;
    assign idx_pick  = req.restart ? INDEX_WIDTH'(start_index_reg) : sample_index_reg;
    assign quot_zero = (quot == '0);
    assign raddr     = count_reg[AW-1:0] - AW'(1);

    hp_divider #(
        .DW(DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .load_value(div_value),
        .base      (base_eff),
        .quot      (quot),
        .rem       (rem),
        .busy      (div_busy)
    );

    hp_digit_mem #(
        .DEPTH(INDEX_WIDTH),
        .AW   (AW)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(rem),
        .raddr(raddr),
        .rdata(digit)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_XCHK;
                end
            end
            ST_XCHK:
            begin
                state_next = quot_zero ? ST_FCHK : ST_XDIV;
            end
            ST_XDIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_XSTORE;
                end
            end
            ST_XSTORE:
            begin
                state_next = ST_XCHK;
            end
            ST_FCHK:
            begin
                if (count_reg != '0)
                begin
                    state_next = ST_FREAD;
                end
                else
                begin
                    state_next = sel_reg ? ST_DONE : ST_XCHK;
                end
            end
            ST_FREAD:
            begin
                state_next = ST_FDIV;
            end
            ST_FDIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_FCHK;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        div_ctrl     = '0;
        div_value    = DW'(idx_used_reg);
        accept       = 1'b0;
        mem_we       = 1'b0;
        cnt_dec      = 1'b0;
        switch_coord = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                accept        = req.valid;
                div_ctrl.load = req.valid;
                div_value     = DW'(idx_pick);
            end
            ST_XCHK:
            begin
                div_ctrl.start = !quot_zero;
            end
            ST_XSTORE:
            begin
                mem_we = 1'b1;
            end
            ST_FCHK:
            begin
                if (count_reg != '0)
                begin
                    cnt_dec = 1'b1;
                end
                else if (!sel_reg)
                begin
                    switch_coord  = 1'b1;
                    div_ctrl.load = 1'b1;
                end
            end
            ST_FREAD:
            begin
                // Next digit above the radix point, previous fold below it.
                div_ctrl.load  = 1'b1;
                div_ctrl.start = 1'b1;
                div_value      = DW'({digit, quot[FRAC_WIDTH-1:0]});
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                div_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_first_reg  <= BASE_FIRST_RST;
            base_second_reg <= BASE_SECOND_RST;
            start_index_reg <= START_INDEX_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_BASE_FIRST:  base_first_reg  <= cfg_data[BASE_W-1:0];
                CFG_BASE_SECOND: base_second_reg <= cfg_data[BASE_W-1:0];
                CFG_START_INDEX: start_index_reg <= cfg_data;
                default:         base_first_reg  <= base_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_index_reg <= INDEX_WIDTH'(START_INDEX_RST);
            count_reg        <= '0;
            sel_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                sample_index_reg <= idx_pick + INDEX_WIDTH'(1);
                count_reg        <= '0;
                sel_reg          <= 1'b0;
            end
            else if (mem_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
            else if (switch_coord)
            begin
                sel_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_used_reg <= idx_pick;
        end
        if (switch_coord)
        begin
            coord_first_reg <= quot[FRAC_WIDTH-1:0];
        end
        if (out_load)
        begin
            out_first_reg  <= FIELD_W'(coord_first_reg);
            out_second_reg <= FIELD_W'(quot[FRAC_WIDTH-1:0]);
            out_index_reg  <= FIELD_W'(idx_used_reg);
        end
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.coord_first  = out_first_reg;
    assign rsp.coord_second = out_second_reg;
    assign rsp.index_used   = out_index_reg;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for halton_point_2d: directed table, then random phases.
// Depends on hp_pkg and the hp_req_if / hp_rsp_if channel interfaces of the design.
module testbench;
    import hp_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] coord_first;
        logic [FIELD_W-1:0] coord_second;
        logic [FIELD_W-1:0] index_used;
    } point_t;

    typedef enum logic [0:0] {
        ROW_WRITE,
        ROW_DRAW
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [FIELD_W-1:0]   reg_data;
        logic                 restart;
        logic                 fixed;
        point_t               point;
    } step_row_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS = 28;
    localparam int RANDOM_ITEMS  = 800;
    localparam int DRAIN_CYCLES  = 1000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;

    hp_req_if req_if ();
    hp_rsp_if rsp_if ();

    halton_point_2d u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // Predictor state: register copies and the running sample index.
    logic [BASE_W-1:0]  shadow_base_first;
    logic [BASE_W-1:0]  shadow_base_second;
    logic [FIELD_W-1:0] shadow_start;
    logic [FIELD_W-1:0] next_index;

    point_t      expected_points [$];
    step_row_t   directed_rows [DIRECTED_ROWS];
    int unsigned burst_left;
    int unsigned error_count;
    int unsigned drawn_directed;
    int unsigned drawn_random;
    int unsigned points_checked;
    int unsigned phase_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

    // Digits come out least significant first; folding from the top digit down with floor
    // division at every step still gives the floor of the true inverse.
    function automatic logic [FIELD_W-1:0] radical_inverse(input logic [FIELD_W-1:0] idx,
                                                           input logic [BASE_W-1:0] base_reg);
        logic [63:0] radix;
        logic [63:0] rest;
        logic [63:0] acc;
        logic [7:0]  digits [0:63];
        int          count;
        radix = (base_reg < BASE_MIN) ? 64'd2 : 64'(base_reg);
        rest  = 64'(idx);
        acc   = '0;
        count = 0;
        while (rest != 0)
        begin
            digits[count] = 8'(rest % radix);
            rest = rest / radix;
            count++;
        end
        while (count > 0)
        begin
            count--;
            acc = ((64'(digits[count]) << FRAC_WIDTH_DEF) + acc) / radix;
        end
        return acc[FIELD_W-1:0];
    endfunction

    task automatic draw_point(input logic restart_bit, output point_t pt);
        if (restart_bit)
            next_index = shadow_start;
        pt.coord_first  = radical_inverse(next_index, shadow_base_first);
        pt.coord_second = radical_inverse(next_index, shadow_base_second);
        pt.index_used   = next_index;
        next_index      = next_index + FIELD_W'(1);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] which,
                                  input logic [FIELD_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        case (which)
            CFG_BASE_FIRST:  shadow_base_first  = value[BASE_W-1:0];
            CFG_BASE_SECOND: shadow_base_second = value[BASE_W-1:0];
            CFG_START_INDEX: shadow_start       = value;
            default: ;
        endcase
    endtask

    // Registers change only with no request in flight and the result side drained.
    task automatic wait_idle();
        if (req_if.valid)
            req_if.valid <= 1'b0;
        if (cfg_write)
            cfg_write <= 1'b0;
        burst_left = 0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic int unsigned pick_gap();
        case ($urandom_range(0, 7))
            0, 1, 2: return 0;
            7:       return $urandom_range(100, 600);
            default: return $urandom_range(1, 10);
        endcase
    endfunction

    task automatic drive_request(input logic restart_bit, input logic fixed,
                                 input point_t fixed_point);
        point_t      predicted;
        int unsigned gap;
        if (cfg_write)
            cfg_write <= 1'b0;
        if (burst_left == 0)
        begin
            gap        = pick_gap();
            burst_left = $urandom_range(1, 8);
            if (gap != 0)
            begin
                if (req_if.valid)
                    req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_if.valid   <= 1'b1;
        req_if.restart <= restart_bit;
        do
            @(posedge clk);
        while (!req_if.ready);
        burst_left--;
        draw_point(restart_bit, predicted);
        expected_points.insert(expected_points.size(), fixed ? fixed_point : predicted);
    endtask

    function automatic logic [FIELD_W-1:0] base_word();
        logic [FIELD_W-1:0] word;
        word = $urandom;
        case ($urandom_range(0, 9))
            0:       word[BASE_W-1:0] = BASE_MIN;
            1:       word[BASE_W-1:0] = 8'd255;
            2:       word[BASE_W-1:0] = 8'($urandom_range(0, 1));
            3:       word[BASE_W-1:0] = 8'd3;
            default: word[BASE_W-1:0] = 8'($urandom_range(2, 255));
        endcase
        return word;
    endfunction

    // Large indexes in small bases are the slow case, so half of the drawn start indexes are low.
    function automatic logic [FIELD_W-1:0] start_word();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    // The receiver mixes long ready stretches, hard stalls and random toggling.
    initial
    begin
        int unsigned hold;
        hold = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        rsp_if.ready <= 1'b1;
                        hold = $urandom_range(20, 80);
                    end
                    1:
                    begin
                        rsp_if.ready <= 1'b0;
                        hold = $urandom_range(1, 15);
                    end
                    default:
                    begin
                        rsp_if.ready <= 1'($urandom_range(0, 1));
                        hold = $urandom_range(0, 4);
                    end
                endcase
            end
            else
                hold--;
        end
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("point index %0d returned with no request pending", rsp_if.index_used);
                error_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                points_checked++;
                if (rsp_if.coord_first !== want.coord_first)
                begin
                    $error("coord_first: expected %h, got %h", want.coord_first,
                           rsp_if.coord_first);
                    error_count++;
                end
                if (rsp_if.coord_second !== want.coord_second)
                begin
                    $error("coord_second: expected %h, got %h", want.coord_second,
                           rsp_if.coord_second);
                    error_count++;
                end
                if (rsp_if.index_used !== want.index_used)
                begin
                    $error("index_used: expected %h, got %h", want.index_used,
                           rsp_if.index_used);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned batch;
        logic        restart_bit;
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= CFG_BASE_FIRST;
        cfg_data       <= '0;
        req_if.valid   <= 1'b0;
        req_if.restart <= 1'b0;
        shadow_base_first  = BASE_FIRST_RST;
        shadow_base_second = BASE_SECOND_RST;
        shadow_start       = START_INDEX_RST;
        next_index         = START_INDEX_RST;
        burst_left     = 0;
        error_count    = 0;
        drawn_directed = 0;
        drawn_random   = 0;
        points_checked = 0;
        phase_count    = 0;

        // Fixed rows hold values that follow directly from the radix expansion.
        directed_rows = '{
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b0, 1'b1, '{32'h0, 32'h0, 32'd0}},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b0, 1'b1,
              '{32'h8000_0000, 32'h5555_5555, 32'd1}},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b0, 1'b1,
              '{32'h4000_0000, 32'hAAAA_AAAA, 32'd2}},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b0, 1'b1,
              '{32'hC000_0000, 32'h1C71_C71C, 32'd3}},
            '{ROW_WRITE, CFG_START_INDEX, 32'd5, 1'b0, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b0, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b1, 1'b0, '0},
            '{ROW_WRITE, CFG_START_INDEX, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b1, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b0, 1'b1, '{32'h0, 32'h0, 32'd0}},
            '{ROW_WRITE, CFG_BASE_FIRST,  32'hFFFF_FF00, 1'b0, 1'b0, '0},
            '{ROW_WRITE, CFG_BASE_SECOND, 32'd1, 1'b0, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b1, 1'b1,
              '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
            '{ROW_WRITE, CFG_BASE_FIRST,  32'd255, 1'b0, 1'b0, '0},
            '{ROW_WRITE, CFG_BASE_SECOND, 32'd255, 1'b0, 1'b0, '0},
            '{ROW_WRITE, CFG_START_INDEX, 32'd1, 1'b0, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b1, 1'b1,
              '{32'h0101_0101, 32'h0101_0101, 32'd1}},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b0, 1'b0, '0},
            '{ROW_WRITE, CFG_UNUSED,      32'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b1, 1'b1,
              '{32'h0101_0101, 32'h0101_0101, 32'd1}},
            '{ROW_WRITE, CFG_BASE_FIRST,  32'd7, 1'b0, 1'b0, '0},
            '{ROW_WRITE, CFG_BASE_SECOND, 32'd254, 1'b0, 1'b0, '0},
            '{ROW_WRITE, CFG_START_INDEX, 32'hAAAA_AAAA, 1'b0, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b1, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b0, 1'b0, '0},
            '{ROW_WRITE, CFG_START_INDEX, 32'h5555_5555, 1'b0, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b1, 1'b0, '0},
            '{ROW_DRAW,  CFG_BASE_FIRST,  32'h0, 1'b0, 1'b0, '0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                wait_idle();
                write_register(directed_rows[r].reg_index, directed_rows[r].reg_data);
            end
            else
            begin
                drive_request(directed_rows[r].restart, directed_rows[r].fixed,
                              directed_rows[r].point);
                drawn_directed++;
            end
        end

        while (drawn_random < RANDOM_ITEMS)
        begin
            wait_idle();
            phase_count++;
            if ($urandom_range(0, 3) != 0)
                write_register(CFG_BASE_FIRST, base_word());
            if ($urandom_range(0, 3) != 0)
                write_register(CFG_BASE_SECOND, base_word());
            if ($urandom_range(0, 3) != 0)
                write_register(CFG_START_INDEX, start_word());
            if ($urandom_range(0, 15) == 0)
                write_register(CFG_UNUSED, $urandom);
            batch = $urandom_range(20, 60);
            for (int i = 0; i < batch; i++)
            begin
                if (i == 0)
                    restart_bit = 1'($urandom_range(0, 1));
                else
                    restart_bit = ($urandom_range(0, 9) == 0);
                drive_request(restart_bit, 1'b0, '0);
                drawn_random++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Requested %0d directed and %0d random points over %0d register settings.",
                 drawn_directed, drawn_random, phase_count);
        $display("Checked %0d returned points, %0d mismatches.", points_checked, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
